// ===== hw/rtl/polyline_arc_length_match_macros.svh =====
// assertion macros for the polyline arc length match checker
// no dependencies
`ifndef POLYLINE_ARC_LENGTH_MATCH_MACROS_SVH
`define POLYLINE_ARC_LENGTH_MATCH_MACROS_SVH
// implication check under reset
`define PALM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// next-cycle implication check under reset
`define PALM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// ===== hw/rtl/palm_pkg.sv =====
// shared types and constants for polyline arc length match
// no dependencies
package palm_pkg;
	localparam int MAX_POINTS = 64;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_DROP = 2'd2;
	localparam int IN_W = 104;
	localparam int OUT_W = 40;
	localparam logic [40:0] PROJ_LIMIT = 41'h100_0000_0000;

	// one stored path point
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] s;
	} point_t;

	// control from the sequencer to the cell row
	typedef struct packed {
		logic clear;
		logic load;
		logic shift;
	} row_ctl_t;
endpackage

// ===== hw/rtl/palm_cell.sv =====
// one point cell of the path row: holds a point and rotates it to its neighbor
// depends on palm_pkg
module palm_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  palm_pkg::row_ctl_t ctl,
	input  palm_pkg::point_t prev_pt,
	input  logic             prev_vld,
	output palm_pkg::point_t pt,
	output logic             vld
);
	import palm_pkg::*;
	point_t pt_q;
	logic   vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clear) begin
			vld_q <= 1'b0;
		end else if (ctl.shift || ctl.load) begin
			vld_q <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift || ctl.load) begin
			pt_q <= prev_pt;
		end
	end

	assign pt = pt_q;
	assign vld = vld_q;
endmodule

// ===== hw/rtl/palm_divsqrt.sv =====
// bit-serial square root and restoring divider for the projection
// depends on palm_pkg
module palm_divsqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [64:0]  l2,
	input  logic [65:0]  dot,
	output logic         done,
	output logic [40:0]  quo
);
	import palm_pkg::*;
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SQRT = 2'd1;
	localparam logic [1:0] PH_DIV = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	logic [1:0]  ph_q;
	logic [6:0]  bit_q;
	logic [34:0] root_q;
	logic [64:0] l2_q;
	logic [65:0] dot_q;
	logic [66:0] rem_q;
	logic [40:0] quo_q;
	logic [34:0] cand;
	logic [69:0] csq;
	logic [66:0] rem_sh;
	logic [40:0] quo_sh;

	assign cand = root_q | (35'd1 << bit_q[5:0]);
	assign csq = cand * cand;
	assign rem_sh = {rem_q[65:0], dot_q[7'd65 - bit_q]};
	assign quo_sh = (quo_q < PROJ_LIMIT) ? {quo_q[39:0], 1'b0} : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			unique case (ph_q)
				PH_IDLE: begin
					if (start) begin
						ph_q <= PH_SQRT;
						bit_q <= 7'd34;
						root_q <= '0;
						l2_q <= l2;
						dot_q <= dot;
					end
				end
				PH_SQRT: begin
					if ({5'd0, l2_q} >= csq) root_q <= cand;
					if (bit_q == 7'd0) begin
						ph_q <= PH_DIV;
						bit_q <= 7'd0;
						rem_q <= '0;
						quo_q <= '0;
					end else begin
						bit_q <= bit_q - 7'd1;
					end
				end
				PH_DIV: begin
					// dividend bits above 65 are zero, so scan 66 bits
					if (root_q == '0) begin
						quo_q <= '0;
						ph_q <= PH_DONE;
					end else begin
						if (rem_sh >= {32'd0, root_q}) begin
							rem_q <= rem_sh - {32'd0, root_q};
							quo_q <= quo_sh | 41'd1;
						end else begin
							rem_q <= rem_sh;
							quo_q <= quo_sh;
						end
						if (bit_q == 7'd65) ph_q <= PH_DONE;
						else bit_q <= bit_q + 7'd1;
					end
				end
				PH_DONE: ph_q <= PH_IDLE;
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	assign done = (ph_q == PH_DONE);
	assign quo = (quo_q > PROJ_LIMIT) ? PROJ_LIMIT : quo_q;
endmodule

// ===== hw/rtl/polyline_arc_length_match.sv =====
// polyline arc length match: with two or more stored points a query runs a scan rotation, a
// fetch rotation, a product register and the root/divide unit before it answers
// one stored point answers after the fetch rotation, an empty path in the next cycle
// a waiting answer blocks new requests, so a new query is taken only once the last answer has left
// an append passes through S_APP, where the new point shifts into the head of the row
// reset is asynchronous active low: path empty, overflow clear, output empty
module polyline_arc_length_match (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [palm_pkg::IN_W-1:0]   s_tdata,  // restart, point_x, point_y, point_s from low bit
	input  logic                        s_tuser,  // func
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [palm_pkg::OUT_W-1:0]  m_tdata   // matched_s, status
);
	import palm_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_APP   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FETCH = 3'd3;
	localparam logic [2:0] S_DOT   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]       st_q;
	logic [CNT_W-1:0] cnt_q;     // points stored
	logic             ovf_q;
	logic [CNT_W-1:0] step_q;    // rotation step
	logic signed [31:0] qx_q, qy_q;
	point_t           new_q;
	logic [65:0]      bestd_q;
	logic [IDX_W-1:0] best_q;
	logic [65:0]      d_prev_q;  // distance of the previous point in the scan
	logic [65:0]      dlo_q;     // distance of best-1
	logic [65:0]      dhi_q;     // distance of best+1
	point_t           pa_q, pb_q;
	logic [IDX_W-1:0] ia;        // index of the segment start
	logic             out_vld_q;
	logic [31:0]      res_q;
	logic [1:0]       stat_q;

	// cell row, cell 0 is the head; the tail feeds back into the head while rotating
	row_ctl_t ctl;
	point_t   pts [MAX_POINTS];
	logic     vlds [MAX_POINTS];
	point_t   head_in;
	logic     head_vld;

	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
		if (g == 0) begin : g_head
			palm_cell u_cell (.clk, .arst_n, .ctl, .prev_pt(head_in), .prev_vld(head_vld),
				.pt(pts[g]), .vld(vlds[g]));
		end else begin : g_body
			palm_cell u_cell (.clk, .arst_n, .ctl, .prev_pt(pts[g-1]), .prev_vld(vlds[g-1]),
				.pt(pts[g]), .vld(vlds[g]));
		end
	end

	// the point at the tail of the row is the next in index order while rotating
	point_t tail;
	assign tail = pts[MAX_POINTS-1];

	// squared distance of the tail point to the query, one multiplier pair
	logic signed [32:0] dx, dy;
	logic [32:0] adx, ady;
	logic [65:0] pt_dist;
	assign dx = 33'(qx_q) - 33'(tail.x);
	assign dy = 33'(qy_q) - 33'(tail.y);
	assign adx = dx[32] ? 33'(-dx) : 33'(dx);
	assign ady = dy[32] ? 33'(-dy) : 33'(dy);
	assign pt_dist = 66'(adx * adx) + 66'(ady * ady);

	// point i sits at cell cnt-1-i; after r shifts the tail holds point r+cnt-MAX_POINTS
	logic [IDX_W-1:0] idx;
	assign idx = step_q[IDX_W-1:0] + cnt_q[IDX_W-1:0];

	// segment toward the nearer neighbor, the next one on a tie, the only one at an end
	always_comb begin
		if (cnt_q == CNT_W'(1)) ia = '0;
		else if (best_q == IDX_W'(cnt_q - CNT_W'(1))) ia = best_q - IDX_W'(1);
		else if (best_q == '0) ia = '0;
		else if (dlo_q < dhi_q) ia = best_q - IDX_W'(1);
		else ia = best_q;
	end

	// projection operands from the chosen segment
	logic signed [32:0] ex, ey, tx, ty;
	logic [32:0] aex, aey, atx, aty;
	logic [65:0] px, py;
	logic [64:0] l2;
	logic [66:0] pos, neg;
	logic [65:0] dotd;
	assign ex = 33'(pb_q.x) - 33'(pa_q.x);
	assign ey = 33'(pb_q.y) - 33'(pa_q.y);
	assign tx = 33'(qx_q) - 33'(pa_q.x);
	assign ty = 33'(qy_q) - 33'(pa_q.y);
	assign aex = ex[32] ? 33'(-ex) : 33'(ex);
	assign aey = ey[32] ? 33'(-ey) : 33'(ey);
	assign atx = tx[32] ? 33'(-tx) : 33'(tx);
	assign aty = ty[32] ? 33'(-ty) : 33'(ty);
	logic [65:0] pxx_s1, pyy_s1, lxx_s1, lyy_s1;
	logic        nx_s1, ny_s1;
	always_ff @(posedge clk) begin
		pxx_s1 <= atx * aex;
		pyy_s1 <= aty * aey;
		lxx_s1 <= aex * aex;
		lyy_s1 <= aey * aey;
		nx_s1 <= (tx[32] != ex[32]);
		ny_s1 <= (ty[32] != ey[32]);
	end
	assign px = pxx_s1;
	assign py = pyy_s1;
	assign l2 = 65'(lxx_s1) + 65'(lyy_s1);
	assign pos = (nx_s1 ? 67'd0 : 67'(px)) + (ny_s1 ? 67'd0 : 67'(py));
	assign neg = (nx_s1 ? 67'(px) : 67'd0) + (ny_s1 ? 67'(py) : 67'd0);
	assign dotd = (neg >= pos) ? 66'd0 : 66'(pos - neg);

	logic        dv_start, dv_done;
	logic [40:0] quo;
	palm_divsqrt u_dv (.clk, .arst_n, .start(dv_start), .l2, .dot(dotd), .done(dv_done),
		.quo);

	// clamp begin_s + projection to end_s
	logic signed [42:0] sum;
	assign sum = 43'(signed'({2'b0, quo})) + 43'(pa_q.s);

	logic [1:0] sub_q;
	logic       acc;
	assign s_tready = (st_q == S_IDLE) && !out_vld_q;
	assign acc = s_tvalid && s_tready;
	assign dv_start = (st_q == S_DIV) && (sub_q == 2'd0);

	always_comb begin
		ctl = '0;
		head_in = tail;
		head_vld = vlds[MAX_POINTS-1];
		if (acc && s_tuser == FUNC_APPEND && s_tdata[0]) ctl.clear = 1'b1;
		if (st_q == S_APP) begin
			ctl.shift = 1'b1;
			head_in = new_q;
			head_vld = 1'b1;
		end
		if ((st_q == S_SCAN || st_q == S_FETCH) && step_q < CNT_W'(MAX_POINTS)) begin
			ctl.shift = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			out_vld_q <= 1'b0;
			step_q <= '0;
			sub_q <= '0;
		end else begin
			if (m_tvalid && m_tready) out_vld_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (acc) begin
						qx_q <= s_tdata[32:1];
						qy_q <= s_tdata[64:33];
						new_q <= '{x: s_tdata[32:1], y: s_tdata[64:33], s: s_tdata[96:65]};
						if (s_tuser == FUNC_APPEND) begin
							if (s_tdata[0]) begin
								cnt_q <= CNT_W'(1);
								ovf_q <= 1'b0;
								st_q <= S_APP;
							end else if (cnt_q < CNT_W'(MAX_POINTS)) begin
								cnt_q <= cnt_q + CNT_W'(1);
								st_q <= S_APP;
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (cnt_q == '0) begin
							res_q <= '0;
							stat_q <= ST_EMPTY;
							out_vld_q <= 1'b1;
						end else begin
							stat_q <= ovf_q ? ST_DROP : ST_OK;
							step_q <= '0;
							st_q <= S_SCAN;
						end
					end
				end
				// shift the new point into the head; shifting drops the tail which
				// is never valid since the row holds fewer than MAX_POINTS points
				S_APP: st_q <= S_IDLE;
				// rotate until the valid points have passed the tail in index order
				S_SCAN: begin
					if (!vlds[MAX_POINTS-1]) begin
						step_q <= step_q + CNT_W'(1);
					end else begin
						if (idx == '0 || pt_dist < bestd_q) begin
							bestd_q <= pt_dist;
							best_q <= idx;
							dlo_q <= d_prev_q;
							dhi_q <= '1;
						end else if (idx == best_q + IDX_W'(1)) begin
							dhi_q <= pt_dist;
						end
						d_prev_q <= pt_dist;
						step_q <= step_q + CNT_W'(1);
						if (step_q == CNT_W'(MAX_POINTS - 1)) begin
							step_q <= '0;
							st_q <= S_FETCH;
						end
					end
				end
				// second full rotation picks up the segment end points
				S_FETCH: begin
					if (vlds[MAX_POINTS-1] && step_q != CNT_W'(MAX_POINTS)) begin
						if (idx == ia) pa_q <= tail;
						if (idx == ia + IDX_W'(1)) pb_q <= tail;
					end
					if (step_q == CNT_W'(MAX_POINTS)) begin
						if (cnt_q == CNT_W'(1)) begin
							res_q <= pa_q.s;
							out_vld_q <= 1'b1;
							st_q <= S_OUT;
						end else begin
							sub_q <= '0;
							st_q <= S_DOT;
						end
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_DOT: st_q <= S_DIV;
				S_DIV: begin
					sub_q <= 2'd1;
					if (dv_done) begin
						res_q <= (sum > 43'(pb_q.s)) ? pb_q.s : sum[31:0];
						out_vld_q <= 1'b1;
						st_q <= S_OUT;
					end
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {6'd0, stat_q, res_q};
endmodule

// ===== hw/rtl/palm_checker.sv =====
// port checker for polyline arc length match, bound to the top level
// depends on the macros header
`include "polyline_arc_length_match_macros.svh"
module palm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [39:0]  m_tdata
);
	`PALM_ASSERT_IMP(a_status_range, m_tvalid, m_tdata[33:32] != 2'd3)
	`PALM_ASSERT_IMP(a_no_take_while_out, m_tvalid, !s_tready)
	`PALM_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`PALM_ASSERT_NXT(a_append_silent, s_tvalid && s_tready && !s_tuser, !m_tvalid)
endmodule

bind polyline_arc_length_match palm_checker u_palm_checker (.*);

// ===== tb/polyline_arc_length_match_test.sv =====
// self-checking bench for polyline_arc_length_match: path loads and nearest-segment queries
// depends on palm_pkg and the polyline_arc_length_match rtl
module polyline_arc_length_match_test;
	import palm_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;  // restart, point_x, point_y, point_s, zero fill from low bit
	logic         s_tuser;  // func
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;  // matched_s, status, zero fill from low bit

	localparam int DIRECTED_N = 22;
	localparam int RANDOM_N = 1850;
	localparam int IDLE_LIMIT = 200000;

	// one request into the block
	typedef struct {
		logic        func;
		logic        restart;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] ps;
	} request_t;

	// one answer out of the block
	typedef struct {
		logic [31:0] arc;
		logic [1:0]  stat;
	} answer_t;

	polyline_arc_length_match DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor copy of the path table
	logic signed [31:0] path_x [MAX_POINTS];
	logic signed [31:0] path_y [MAX_POINTS];
	logic signed [31:0] path_s [MAX_POINTS];
	int                 path_len;
	bit                 path_dropped;

	answer_t pending_answers[$];
	int      mismatch_count;
	int      answers_seen;
	int      queries_sent;
	int      appends_sent;
	int      drops_seen;
	int      idle_cycles;
	bit      stim_done;
	bit      hold_off;

	always #2 clk = ~clk;

	// squared distance of stored point k from the query, exact in 66 bits
	function automatic logic [65:0] dist_sq(int k, logic signed [31:0] qx,
			logic signed [31:0] qy);
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		dx = 34'(qx) - 34'(path_x[k]);
		dy = 34'(qy) - 34'(path_y[k]);
		return 66'(dx * dx) + 66'(dy * dy);
	endfunction

	// projection of the query onto segment a->b, floored and saturated
	function automatic logic [40:0] seg_projection(int a, int b, logic signed [31:0] qx,
			logic signed [31:0] qy);
		logic signed [33:0]  ex;
		logic signed [33:0]  ey;
		logic signed [33:0]  tx;
		logic signed [33:0]  ty;
		logic [65:0]         len_sq;
		logic [34:0]         root;
		logic [34:0]         trial;
		logic signed [69:0]  dot;
		logic [69:0]         quot;
		ex = 34'(path_x[b]) - 34'(path_x[a]);
		ey = 34'(path_y[b]) - 34'(path_y[a]);
		tx = 34'(qx) - 34'(path_x[a]);
		ty = 34'(qy) - 34'(path_y[a]);
		len_sq = 66'(ex * ex) + 66'(ey * ey);
		if (len_sq == 0)
			return 0;
		root = 0;
		for (int bitpos = 34; bitpos >= 0; bitpos--) begin
			trial = root | (35'd1 << bitpos);
			if (70'(trial) * 70'(trial) <= 70'(len_sq))
				root = trial;
		end
		if (root == 0)
			return 0;
		dot = 70'(tx) * 70'(ex) + 70'(ty) * 70'(ey);
		if (dot <= 0)
			return 0;
		quot = 70'(dot) / 70'(root);
		return (quot > 70'(PROJ_LIMIT)) ? PROJ_LIMIT : 41'(quot);
	endfunction

	// applies one request to the path copy, returns 1 with the answer on a query
	function automatic bit match_arc(request_t rq, output answer_t ans);
		int           best;
		int           a;
		int           b;
		logic [65:0]  best_d;
		logic [65:0]  d;
		logic signed [42:0] sum;
		ans.arc = 0;
		ans.stat = ST_OK;
		if (rq.func == FUNC_APPEND) begin
			if (rq.restart) begin
				path_len = 0;
				path_dropped = 0;
			end
			if (path_len < MAX_POINTS) begin
				path_x[path_len] = rq.px;
				path_y[path_len] = rq.py;
				path_s[path_len] = rq.ps;
				path_len++;
			end else
				path_dropped = 1;
			return 0;
		end
		if (path_len == 0) begin
			ans.stat = ST_EMPTY;
			return 1;
		end
		ans.stat = path_dropped ? ST_DROP : ST_OK;
		if (path_len == 1) begin
			ans.arc = path_s[0];
			return 1;
		end
		// first nearest point wins ties
		best = 0;
		best_d = dist_sq(0, rq.px, rq.py);
		for (int k = 1; k < path_len; k++) begin
			d = dist_sq(k, rq.px, rq.py);
			if (d < best_d) begin
				best_d = d;
				best = k;
			end
		end
		// segment toward the nearer neighbour, next one on a tie
		if (best == path_len - 1) begin
			a = path_len - 2;
			b = path_len - 1;
		end else if (best == 0) begin
			a = 0;
			b = 1;
		end else if (dist_sq(best - 1, rq.px, rq.py) < dist_sq(best + 1, rq.px, rq.py)) begin
			a = best - 1;
			b = best;
		end else begin
			a = best;
			b = best + 1;
		end
		sum = 43'(seg_projection(a, b, rq.px, rq.py)) + 43'(path_s[a]);
		if (sum > 43'(path_s[b]))
			sum = 43'(path_s[b]);
		ans.arc = sum[31:0];
		return 1;
	endfunction

	// directed rows; expected answer typed in where it is obvious, else predicted
	request_t directed_rq [DIRECTED_N];
	bit       directed_fixed [DIRECTED_N];
	answer_t  directed_ans [DIRECTED_N];

	task automatic set_row(int k, logic f, logic r, logic [31:0] x, logic [31:0] y,
			logic [31:0] s, bit fixed, logic [31:0] arc, logic [1:0] st);
		directed_rq[k] = '{f, r, x, y, s};
		directed_fixed[k] = fixed;
		directed_ans[k] = '{arc, st};
	endtask

	initial begin
		// query on the empty path after reset
		set_row(0, FUNC_QUERY, 0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1, 0, ST_EMPTY);
		// single point gives its own arc length
		set_row(1, FUNC_APPEND, 1, 32'h80000000, 32'h7fffffff, 32'h12345678, 0, 0, 0);
		set_row(2, FUNC_QUERY, 0, 32'h7fffffff, 32'h80000000, 0, 1, 32'h12345678, ST_OK);
		// straight segment along x, arc 0..10240
		set_row(3, FUNC_APPEND, 1, 0, 0, 0, 0, 0, 0);
		set_row(4, FUNC_APPEND, 0, 32'd10240, 0, 32'd10240, 0, 0, 0);
		set_row(5, FUNC_QUERY, 0, 32'd5120, 32'd777, 0, 1, 32'd5120, ST_OK);
		set_row(6, FUNC_QUERY, 0, 32'hffff0000, 0, 0, 1, 0, ST_OK);
		set_row(7, FUNC_QUERY, 0, 32'h7fffffff, 32'h7fffffff, 0, 1, 32'd10240, ST_OK);
		// zero-length segment and an equidistant middle point
		set_row(8, FUNC_APPEND, 0, 32'd10240, 0, 32'd20000, 0, 0, 0);
		set_row(9, FUNC_QUERY, 0, 32'd10240, 32'd10, 0, 0, 0, 0);
		set_row(10, FUNC_APPEND, 0, 32'd20480, 0, 32'd5, 0, 0, 0);
		set_row(11, FUNC_QUERY, 0, 32'd15360, 32'd100, 0, 0, 0, 0);
		// decreasing arc length
		set_row(12, FUNC_QUERY, 0, 32'd20000, 0, 0, 0, 0, 0);
		// extreme corners of the plane
		set_row(13, FUNC_APPEND, 1, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
		set_row(14, FUNC_APPEND, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
		set_row(15, FUNC_QUERY, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
		set_row(16, FUNC_QUERY, 0, 32'h7ffffff0, 32'h7ffffff0, 0, 0, 0, 0);
		set_row(17, FUNC_QUERY, 0, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
		// two equal nearest distances, lowest index wins
		set_row(18, FUNC_APPEND, 1, 0, 32'd1000, 32'd1, 0, 0, 0);
		set_row(19, FUNC_APPEND, 0, 0, 32'hfffffc18, 32'd2, 0, 0, 0);
		set_row(20, FUNC_APPEND, 0, 32'd5000, 0, 32'd3, 0, 0, 0);
		set_row(21, FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0);
	end

	// drives one request, held until accepted; bursts with random gaps
	int burst_left;
	task automatic send_request(request_t rq);
		answer_t ans;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1;
		s_tuser <= rq.func;
		s_tdata <= {7'd0, rq.ps, rq.py, rq.px, rq.restart};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (match_arc(rq, ans)) begin
			pending_answers.push_back(ans);
			queries_sent++;
		end else begin
			appends_sent++;
			if (path_dropped)
				drops_seen++;
		end
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 200000)) - 100000);
			default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 50)
				: 32'h80000000 + $urandom_range(0, 50);
		endcase
	endfunction

	// a path run: restart then points roughly along a walk, queries between
	task automatic random_phase(int count);
		int       mode;
		int       path_size;
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] ws;
		int       sent;
		sent = 0;
		while (sent < count) begin
			mode = $urandom_range(0, 9) < 7 ? 1 : ($urandom_range(0, 1) ? 0 : 2);
			// mostly short paths, sometimes past capacity
			path_size = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
				: $urandom_range(0, 8);
			wx = rand_coord(mode);
			wy = rand_coord(mode);
			ws = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000);
			for (int k = 0; k < path_size; k++) begin
				send_request('{FUNC_APPEND, (k == 0), wx, wy, ws});
				sent++;
				if ($urandom_range(0, 3) == 0) begin
					send_request('{FUNC_QUERY, 1'($urandom_range(0, 1)),
						wx + $urandom_range(0, 3000) - 1500,
						wy + $urandom_range(0, 3000) - 1500, $urandom});
					sent++;
				end
				wx = (mode == 1) ? wx + $urandom_range(0, 4000) - 1000 : rand_coord(mode);
				wy = (mode == 1) ? wy + $urandom_range(0, 4000) - 1000 : rand_coord(mode);
				ws = (mode == 1 && $urandom_range(0, 7) != 0) ? ws + $urandom_range(0, 4000)
					: $urandom;
			end
			repeat ($urandom_range(1, 5)) begin
				send_request('{FUNC_QUERY, 1'($urandom_range(0, 1)), rand_coord(mode),
					rand_coord(mode), $urandom});
				sent++;
			end
		end
	endtask

	// stimulus
	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = 0;
		burst_left = 0;
		path_len = 0;
		path_dropped = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int k = 0; k < DIRECTED_N; k++) begin
			if (directed_fixed[k]) begin
				send_request(directed_rq[k]);
				// typed answer replaces the predicted one
				void'(pending_answers.pop_back());
				pending_answers.push_back(directed_ans[k]);
			end else
				send_request(directed_rq[k]);
		end
		random_phase(RANDOM_N);
		s_tvalid <= 0;
		stim_done = 1;
	end

	// receiver stalls on its own pattern, with one long hold-off
	initial begin
		m_tready = 0;
		hold_off = 0;
		wait (arst_n);
		m_tready <= 1;
		repeat (600) @(posedge clk);
		hold_off = 1;
		m_tready <= 0;
		repeat (3000) @(posedge clk);
		hold_off = 0;
		forever begin
			@(posedge clk);
			case ($urandom_range(0, 7))
				0, 1: m_tready <= 0;
				2: m_tready <= ($urandom_range(0, 15) == 0);
				default: m_tready <= 1;
			endcase
		end
	end

	// compare each accepted answer with the oldest expectation
	answer_t want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected answer %h", m_tdata);
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[31:0] !== want.arc || m_tdata[33:32] !== want.stat
						|| m_tdata[39:34] !== 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("answer %0d: expected arc %h status %0d, got arc %h status %0d",
							answers_seen, want.arc, want.stat, m_tdata[31:0], m_tdata[33:32]);
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		mismatch_count = 0;
		answers_seen = 0;
		queries_sent = 0;
		appends_sent = 0;
		drops_seen = 0;
		idle_cycles = 0;
		stim_done = 0;
		fork
			begin
				wait (stim_done && pending_answers.size() == 0);
				// an append after the last answer may still be shifting into the row
				repeat (400) @(posedge clk);
			end
			begin
				wait (idle_cycles >= IDLE_LIMIT);
			end
		join_any
		$display("covered %0d appends (%0d dropped) and %0d queries, %0d answers checked",
			appends_sent, drops_seen, queries_sent, answers_seen);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout waiting for handshake");
			$display("polyline_arc_length_match test failed");
		end else if (mismatch_count == 0 && pending_answers.size() == 0) begin
			$display("polyline_arc_length_match test passed");
		end else begin
			$display("%0d mismatches, %0d answers missing", mismatch_count,
				pending_answers.size());
			$display("polyline_arc_length_match test failed");
		end
		$finish;
	end
endmodule
